>>> rtl/core/iee_pkg.sv
package iee_pkg;

  localparam int unsigned VAL_W       = 48;
  localparam int unsigned MANT_W      = 47;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned OUT_TDATA_W = ((VAL_W + STAT_W + 7) / 8) * 8;
  localparam int unsigned MUL_CHUNK   = 16;
  localparam int unsigned DEPTH_W     = 16;

  localparam logic [MANT_W-1:0]        MANT_CAP = '1;
  localparam logic signed [VAL_W-1:0]  QMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0]  QMIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [DEPTH_W-1:0]       DEPTH_MAX = '1;
  localparam logic [2:0]               FD_MAX = 3'd7;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_LP    = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RP    = 8'h29;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // error flag bit positions
  localparam int unsigned ERR_UNB = 0;
  localparam int unsigned ERR_OVF = 1;
  localparam int unsigned ERR_DIV = 2;

  typedef enum logic [2:0] {K_DIGIT, K_POINT, K_OP, K_LP, K_RP, K_OTHER} kind_e;
  typedef enum logic [2:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LP} op_e;
  typedef enum logic [1:0] {ST_OK, ST_UNBAL, ST_OVF, ST_DIVZ} status_e;
  typedef enum logic [1:0] {L_OP, L_RP, L_FIN} loop_e;
  typedef enum logic [3:0] {
    S_IDLE, S_ENDNUM, S_NDIV, S_ACT, S_LOOP, S_POST,
    S_RED_B, S_RED_A, S_EXEC, S_MUL, S_DDIV, S_OUT
  } state_e;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] digit;
    op_e        op;
    logic       last;
  } cmd_t;

  function automatic logic [23:0] pow10(input logic [2:0] n);
    logic [23:0] r;
    unique case (n)
      3'd0: r = 24'd1;
      3'd1: r = 24'd10;
      3'd2: r = 24'd100;
      3'd3: r = 24'd1000;
      3'd4: r = 24'd10000;
      3'd5: r = 24'd100000;
      3'd6: r = 24'd1000000;
      default: r = 24'd10000000;
    endcase
    return r;
  endfunction

  // hi: magnitude has bits above VAL_W
  function automatic logic signed [VAL_W-1:0] from_mag(input logic neg, input logic hi,
                                                       input logic [VAL_W-1:0] m);
    logic signed [VAL_W-1:0] r;
    if (neg) begin
      if (hi || (m > {1'b1, {(VAL_W-1){1'b0}}})) r = QMIN;
      else r = $signed(VAL_W'(-m));
    end else begin
      if (hi || m[VAL_W-1]) r = QMAX;
      else r = $signed(m);
    end
    return r;
  endfunction

  function automatic logic reduces_before(input op_e top, input op_e inc);
    logic r;
    priority if (top == OP_MUL || top == OP_DIV) r = 1'b1;
    else if (top == OP_ADD || top == OP_SUB) r = (inc == OP_ADD) || (inc == OP_SUB);
    else r = 1'b0;
    return r;
  endfunction

  function automatic cmd_t classify(input logic [CHAR_W-1:0] c, input logic last);
    cmd_t r;
    r.kind  = K_OTHER;
    r.digit = 4'(c - CH_ZERO);
    r.op    = OP_LP;
    r.last  = last;
    priority if (c >= CH_ZERO && c <= CH_NINE) r.kind = K_DIGIT;
    else if (c == CH_POINT) r.kind = K_POINT;
    else if (c == CH_PLUS) begin r.kind = K_OP; r.op = OP_ADD; end
    else if (c == CH_MINUS) begin r.kind = K_OP; r.op = OP_SUB; end
    else if (c == CH_MUL) begin r.kind = K_OP; r.op = OP_MUL; end
    else if (c == CH_DIV) begin r.kind = K_OP; r.op = OP_DIV; end
    else if (c == CH_LP) r.kind = K_LP;
    else if (c == CH_RP) r.kind = K_RP;
    else r.kind = K_OTHER;
    return r;
  endfunction

endpackage

>>> rtl/core/infix_expression_evaluator.sv
// Channel   Direction  tdata                          tuser/tlast
// s_axis    in         [7:0] char_code                tlast = last_char
// m_axis    out        [47:0] value, [49:48] status   -
//
// A digit or '.' is handled in the engine's idle state; other characters
// go through further states. Ending a number runs the shared divider.
// Each reduction passes through RED_B, RED_A and EXEC; '*' adds the MUL
// state, '/' the same divider. Stacks have separate read and write ports.
// A two-entry queue separates the input stage from the engine, and the
// result register lets the next expression start while a result waits.
module infix_expression_evaluator import iee_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [CHAR_W-1:0]      s_axis_tdata_i,   // [7:0] char_code
  input  logic                   s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o    // [47:0] value, [49:48] status
);

  logic                    front_vld, fifo_rdy, cmd_vld, cmd_rdy;
  cmd_t                    front_cmd, cmd;
  logic signed [VAL_W-1:0] value;
  status_e                 status;

  iee_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .char_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .cmd_valid_o (front_vld),
    .cmd_ready_i (fifo_rdy),
    .cmd_o       (front_cmd)
  );

  iee_fifo #(.DEPTH(2)) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_vld),
    .wr_ready_o (fifo_rdy),
    .wr_cmd_i   (front_cmd),
    .rd_valid_o (cmd_vld),
    .rd_ready_i (cmd_rdy),
    .rd_cmd_o   (cmd)
  );

  iee_back #(.STACK_DEPTH(STACK_DEPTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_vld),
    .cmd_ready_o (cmd_rdy),
    .cmd_i       (cmd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .value_o     (value),
    .status_o    (status)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'({status, value});

  a_err_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[VAL_W+STAT_W-1:VAL_W] != ST_OK)
      |-> m_axis_tdata_o[VAL_W-1:0] == '0)
    else $error("error status with non-zero value");

  a_front_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_vld && !fifo_rdy |=> front_vld && $stable(front_cmd))
    else $error("front item lost while queue full");

endmodule

>>> rtl/core/iee_front.sv
module iee_front import iee_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CHAR_W-1:0] char_i,
  input  logic              last_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);

  logic vld_q;
  cmd_t cmd_q;

  assign in_ready_o  = !vld_q || cmd_ready_i;
  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= classify(char_i, last_i);
    end
  end

endmodule

>>> rtl/core/iee_fifo.sv
module iee_fifo import iee_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_cmd_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_cmd_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] cnt_q;
  logic          push, pop;

  assign wr_ready_o = cnt_q != NW'(DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_cmd_o   = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      if (push && !pop) cnt_q <= cnt_q + NW'(1);
      else if (pop && !push) cnt_q <= cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_cmd_i;
  end

endmodule

>>> rtl/core/iee_div.sv
module iee_div #(
  parameter int unsigned DW = 64,
  parameter int unsigned VW = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo_q;
  logic [VW-1:0]   rem_q, div_q;
  logic [CNTW-1:0] cnt_q;
  logic            run_q, done_q;
  logic [VW:0]     rem_sh;
  logic            ge;
  logic [VW:0]     rem_n;

  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign ge     = rem_sh >= {1'b0, div_q};
  assign rem_n  = ge ? rem_sh - {1'b0, div_q} : rem_sh;
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNTW'(DW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= rem_n[VW-1:0];
    end
  end

endmodule

>>> rtl/core/iee_back.sv
module iee_back import iee_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_valid_i,
  output logic                    cmd_ready_o,
  input  cmd_t                    cmd_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [VAL_W-1:0] value_o,
  output status_e                 status_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DW = VAL_W + FRAC_BITS;
  localparam int unsigned PW = 2 * VAL_W;
  localparam int unsigned NW = MANT_W + 4;

  // stacks
  logic signed [VAL_W-1:0] vstk [STACK_DEPTH];
  op_e                     ostk [STACK_DEPTH];

  state_e                  state_q, state_d;
  loop_e                   loop_q, loop_d;
  cmd_t                    cmd_q, cmd_d;
  logic [CW-1:0]           vcnt_q, vcnt_d, ocnt_q, ocnt_d;
  logic [DEPTH_W-1:0]      depth_q, depth_d;
  logic [MANT_W-1:0]       acc_q, acc_d;
  logic [2:0]              fd_q, fd_d;
  logic                    in_num_q, in_num_d, after_pt_q, after_pt_d;
  logic                    neg_next_q, neg_next_d, neg_ok_q, neg_ok_d;
  logic [2:0]              err_q, err_d;
  op_e                     op_q, op_d;
  logic signed [VAL_W-1:0] a_q, a_d, b_q, b_d;
  logic [VAL_W-1:0]        ma_q, ma_d, mb_q, mb_d;
  logic                    sgn_q, sgn_d;
  logic [PW-1:0]           prod_q, prod_d;
  logic [1:0]              step_q, step_d;
  logic                    out_vld_q, out_vld_d;
  logic signed [VAL_W-1:0] out_val_q, out_val_d;
  status_e                 out_st_q, out_st_d;
  logic signed [VAL_W-1:0] vtop_q;
  op_e                     otop_q;

  logic                    vpush, opush, vpush_ok, opush_ok;
  logic signed [VAL_W-1:0] vpush_val;
  op_e                     opush_code;
  logic [CW-1:0]           vdec, odec;

  logic                    div_start, div_done;
  logic [DW-1:0]           div_dividend, div_quot;
  logic [VAL_W-1:0]        div_divisor;

  logic [MANT_W-1:0]       acc_b;
  logic [2:0]              fd_b;
  logic [NW-1:0]           acc_n;
  logic [VAL_W-1:0]        mag_a, mag_b;
  logic [VAL_W:0]          sum;
  logic [2*MUL_CHUNK+VAL_W-MUL_CHUNK-1:0] pp;
  logic signed [VAL_W-1:0] nval;
  status_e                 st;

  iee_div #(.DW(DW), .VW(VAL_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign cmd_ready_o = state_q == S_IDLE;
  assign out_valid_o = out_vld_q;
  assign value_o     = out_val_q;
  assign status_o    = out_st_q;

  assign acc_b = in_num_q ? acc_q : '0;
  assign fd_b  = in_num_q ? fd_q : 3'd0;
  assign acc_n = (NW'(acc_b) << 3) + (NW'(acc_b) << 1) + NW'(cmd_i.digit);
  assign mag_a = a_q[VAL_W-1] ? VAL_W'(-a_q) : VAL_W'(a_q);
  assign mag_b = b_q[VAL_W-1] ? VAL_W'(-b_q) : VAL_W'(b_q);
  assign pp    = ma_q * mb_q[MUL_CHUNK-1:0];

  always_comb begin
    nval = from_mag(1'b0, |div_quot[DW-1:VAL_W], div_quot[VAL_W-1:0]);
    if (neg_next_q) nval = -nval;
  end

  always_comb begin
    priority if (err_q[ERR_UNB]) st = ST_UNBAL;
    else if (err_q[ERR_OVF]) st = ST_OVF;
    else if (err_q[ERR_DIV]) st = ST_DIVZ;
    else st = ST_OK;
  end

  always_comb begin
    state_d    = state_q;
    loop_d     = loop_q;
    cmd_d      = cmd_q;
    vcnt_d     = vcnt_q;
    ocnt_d     = ocnt_q;
    depth_d    = depth_q;
    acc_d      = acc_q;
    fd_d       = fd_q;
    in_num_d   = in_num_q;
    after_pt_d = after_pt_q;
    neg_next_d = neg_next_q;
    neg_ok_d   = neg_ok_q;
    err_d      = err_q;
    op_d       = op_q;
    a_d        = a_q;
    b_d        = b_q;
    ma_d       = ma_q;
    mb_d       = mb_q;
    sgn_d      = sgn_q;
    prod_d     = prod_q;
    step_d     = step_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_val_d  = out_val_q;
    out_st_d   = out_st_q;
    vpush      = 1'b0;
    vpush_val  = '0;
    opush      = 1'b0;
    opush_code = OP_LP;
    div_start  = 1'b0;
    div_dividend = DW'({acc_q, {FRAC_BITS{1'b0}}});
    div_divisor  = VAL_W'(pow10(fd_q));
    sum = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          unique case (cmd_i.kind)
            K_DIGIT: begin
              in_num_d = 1'b1;
              acc_d    = acc_b;
              fd_d     = fd_b;
              if (acc_b != MANT_CAP && !(after_pt_q && fd_b == FD_MAX)) begin
                if (acc_n > NW'(MANT_CAP)) begin
                  acc_d = MANT_CAP;
                  fd_d  = 3'd0;
                end else begin
                  acc_d = acc_n[MANT_W-1:0];
                  if (after_pt_q) fd_d = fd_b + 3'd1;
                end
              end
              neg_ok_d = 1'b0;
              state_d  = cmd_i.last ? S_ENDNUM : S_IDLE;
            end
            K_POINT: begin
              in_num_d   = 1'b1;
              acc_d      = acc_b;
              fd_d       = fd_b;
              after_pt_d = 1'b1;
              neg_ok_d   = 1'b0;
              state_d    = cmd_i.last ? S_ENDNUM : S_IDLE;
            end
            default: state_d = S_ENDNUM;
          endcase
        end
      end
      S_ENDNUM: begin
        if (in_num_q) begin
          div_start = 1'b1;
          state_d   = S_NDIV;
        end else begin
          state_d = S_ACT;
        end
      end
      S_NDIV: begin
        if (div_done) begin
          vpush      = 1'b1;
          vpush_val  = nval;
          in_num_d   = 1'b0;
          after_pt_d = 1'b0;
          acc_d      = '0;
          fd_d       = 3'd0;
          neg_next_d = 1'b0;
          state_d    = S_ACT;
        end
      end
      S_ACT: begin
        state_d = S_POST;
        unique case (cmd_q.kind)
          K_OP: begin
            neg_ok_d = 1'b1;
            if (cmd_q.op == OP_SUB && neg_ok_q) begin
              neg_next_d = 1'b1;
            end else begin
              loop_d  = L_OP;
              state_d = S_LOOP;
            end
          end
          K_LP: begin
            opush      = 1'b1;
            opush_code = OP_LP;
            if (depth_q != DEPTH_MAX) depth_d = depth_q + DEPTH_W'(1);
            neg_ok_d = 1'b1;
          end
          K_RP: begin
            neg_ok_d = 1'b0;
            if (depth_q == '0) begin
              err_d[ERR_UNB] = 1'b1;
            end else begin
              depth_d = depth_q - DEPTH_W'(1);
              loop_d  = L_RP;
              state_d = S_LOOP;
            end
          end
          default: ;
        endcase
      end
      S_LOOP: begin
        unique case (loop_q)
          L_OP: begin
            if (ocnt_q != '0 && reduces_before(otop_q, cmd_q.op)) begin
              state_d = S_RED_B;
            end else begin
              opush      = 1'b1;
              opush_code = cmd_q.op;
              state_d    = S_POST;
            end
          end
          L_RP: begin
            if (ocnt_q != '0 && otop_q != OP_LP) begin
              state_d = S_RED_B;
            end else begin
              if (ocnt_q != '0) ocnt_d = ocnt_q - CW'(1);
              state_d = S_POST;
            end
          end
          default: begin
            if (ocnt_q != '0) begin
              if (otop_q == OP_LP) ocnt_d = ocnt_q - CW'(1);
              else state_d = S_RED_B;
            end else begin
              if (depth_q != '0) err_d[ERR_UNB] = 1'b1;
              state_d = S_OUT;
            end
          end
        endcase
      end
      S_POST: begin
        if (cmd_q.last) begin
          loop_d  = L_FIN;
          state_d = S_LOOP;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RED_B: begin
        op_d   = otop_q;
        ocnt_d = ocnt_q - CW'(1);
        b_d    = (vcnt_q != '0) ? vtop_q : '0;
        if (vcnt_q != '0) vcnt_d = vcnt_q - CW'(1);
        state_d = S_RED_A;
      end
      S_RED_A: begin
        a_d = (vcnt_q != '0) ? vtop_q : '0;
        if (vcnt_q != '0) vcnt_d = vcnt_q - CW'(1);
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_LOOP;
        unique case (op_q)
          OP_ADD, OP_SUB: begin
            if (op_q == OP_ADD) sum = {a_q[VAL_W-1], a_q} + {b_q[VAL_W-1], b_q};
            else sum = {a_q[VAL_W-1], a_q} - {b_q[VAL_W-1], b_q};
            vpush = 1'b1;
            if (sum[VAL_W] != sum[VAL_W-1]) vpush_val = sum[VAL_W] ? QMIN : QMAX;
            else vpush_val = $signed(sum[VAL_W-1:0]);
          end
          OP_MUL: begin
            ma_d    = mag_a;
            mb_d    = mag_b;
            sgn_d   = a_q[VAL_W-1] ^ b_q[VAL_W-1];
            prod_d  = '0;
            step_d  = 2'd0;
            state_d = S_MUL;
          end
          OP_DIV: begin
            if (b_q == '0) begin
              err_d[ERR_DIV] = 1'b1;
              vpush     = 1'b1;
              vpush_val = '0;
            end else begin
              sgn_d        = a_q[VAL_W-1] ^ b_q[VAL_W-1];
              div_start    = 1'b1;
              div_dividend = {mag_a, {FRAC_BITS{1'b0}}};
              div_divisor  = mag_b;
              state_d      = S_DDIV;
            end
          end
          default: begin
            vpush     = 1'b1;
            vpush_val = '0;
          end
        endcase
      end
      S_MUL: begin
        if (step_q == 2'd3) begin
          vpush     = 1'b1;
          vpush_val = from_mag(sgn_q, (prod_q >> (VAL_W + FRAC_BITS)) != '0,
                               prod_q[FRAC_BITS +: VAL_W]);
          state_d   = S_LOOP;
        end else begin
          prod_d = prod_q + (PW'(pp) << {step_q, 4'b0000});
          mb_d   = mb_q >> MUL_CHUNK;
          step_d = step_q + 2'd1;
        end
      end
      S_DDIV: begin
        if (div_done) begin
          vpush     = 1'b1;
          vpush_val = from_mag(sgn_q, |div_quot[DW-1:VAL_W], div_quot[VAL_W-1:0]);
          state_d   = S_LOOP;
        end
      end
      S_OUT: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d  = 1'b1;
          out_st_d   = st;
          out_val_d  = (st != ST_OK || vcnt_q == '0) ? '0 : vtop_q;
          vcnt_d     = '0;
          ocnt_d     = '0;
          depth_d    = '0;
          acc_d      = '0;
          fd_d       = 3'd0;
          in_num_d   = 1'b0;
          after_pt_d = 1'b0;
          neg_next_d = 1'b0;
          neg_ok_d   = 1'b1;
          err_d      = '0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    vpush_ok = vpush && (vcnt_q < CW'(STACK_DEPTH));
    opush_ok = opush && (ocnt_q < CW'(STACK_DEPTH));
    if (vpush) begin
      if (vpush_ok) vcnt_d = vcnt_q + CW'(1);
      else err_d[ERR_OVF] = 1'b1;
    end
    if (opush) begin
      if (opush_ok) ocnt_d = ocnt_q + CW'(1);
      else err_d[ERR_OVF] = 1'b1;
    end
    vdec = vcnt_d - CW'(1);
    odec = ocnt_d - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      loop_q     <= L_OP;
      vcnt_q     <= '0;
      ocnt_q     <= '0;
      depth_q    <= '0;
      acc_q      <= '0;
      fd_q       <= 3'd0;
      in_num_q   <= 1'b0;
      after_pt_q <= 1'b0;
      neg_next_q <= 1'b0;
      neg_ok_q   <= 1'b1;
      err_q      <= '0;
      step_q     <= 2'd0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      loop_q     <= loop_d;
      vcnt_q     <= vcnt_d;
      ocnt_q     <= ocnt_d;
      depth_q    <= depth_d;
      acc_q      <= acc_d;
      fd_q       <= fd_d;
      in_num_q   <= in_num_d;
      after_pt_q <= after_pt_d;
      neg_next_q <= neg_next_d;
      neg_ok_q   <= neg_ok_d;
      err_q      <= err_d;
      step_q     <= step_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    op_q      <= op_d;
    a_q       <= a_d;
    b_q       <= b_d;
    ma_q      <= ma_d;
    mb_q      <= mb_d;
    sgn_q     <= sgn_d;
    prod_q    <= prod_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
  end

  // stack tops follow the next count, push data bypassed
  always_ff @(posedge clk_i) begin
    if (vpush_ok) vstk[vcnt_q[AW-1:0]] <= vpush_val;
    vtop_q <= vpush_ok ? vpush_val : vstk[vdec[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (opush_ok) ostk[ocnt_q[AW-1:0]] <= opush_code;
    otop_q <= opush_ok ? opush_code : ostk[odec[AW-1:0]];
  end

endmodule
